[src/mono_sprite_clip_blit_defines.svh]
// Assertion macros for the blitter modules; only mscb_fifo uses them.
`ifndef MONO_SPRITE_CLIP_BLIT_DEFINES_SVH
`define MONO_SPRITE_CLIP_BLIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checked out of reset only.
`define MSCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define MSCB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MSCB_ASSERT(lbl, prop, msg)
`define MSCB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[src/mscb_pkg.sv]
package mscb_pkg;

  localparam int unsigned COORD_BITS        = 16;
  localparam int unsigned ADDR_BITS         = 32;
  localparam int unsigned ORIGIN_BITS       = COORD_BITS + 2;
  localparam int unsigned VP_BITS           = 12;
  localparam int unsigned PITCH_BITS        = 16;
  localparam int unsigned DATA_BITS         = 32;
  localparam int unsigned NARROW_PIXEL_BITS = 16;
  localparam int unsigned CFG_IDX_BITS      = 4;
  localparam int unsigned FIFO_DEPTH        = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_VP_X_MIN   = 4'd0,
    CFG_VP_X_MAX   = 4'd1,
    CFG_VP_Y_MIN   = 4'd2,
    CFG_VP_Y_MAX   = 4'd3,
    CFG_LINE_PITCH = 4'd4,
    CFG_FRAME_BASE = 4'd5,
    CFG_COLOUR     = 4'd6,
    CFG_WIDE       = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                          first;
    logic [7:0]                    sprite_byte;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_y;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] write_address;
    logic [DATA_BITS-1:0] write_data;
    logic                 write_wide;
  } out_word_t;

  typedef struct packed {
    logic [VP_BITS-1:0]    vp_x_min;
    logic [VP_BITS-1:0]    vp_x_max;
    logic [VP_BITS-1:0]    vp_y_min;
    logic [VP_BITS-1:0]    vp_y_max;
    logic [PITCH_BITS-1:0] line_pitch;
    logic [31:0]           frame_base;
    logic [DATA_BITS-1:0]  draw_colour;
    logic                  wide_pixels;
  } cfg_t;

  // Pixel known to be inside the viewport, so both coordinates fit VP_BITS.
  typedef struct packed {
    logic [VP_BITS-1:0] px;
    logic [VP_BITS-1:0] py;
  } pix_t;

  localparam cfg_t CFG_RESET = '{
    vp_x_min:    12'd0,
    vp_x_max:    12'd639,
    vp_y_min:    12'd0,
    vp_y_max:    12'd479,
    line_pitch:  16'd1280,
    frame_base:  32'd0,
    draw_colour: 32'd0,
    wide_pixels: 1'b0
  };

endpackage

[src/mscb_front.sv]
module mscb_front
  import mscb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_data_i,
  input  logic     fifo_full_i,
  output logic     push_o,
  output pix_t     pix_o
);

  typedef enum logic [4:0] {
    HDR_IDLE   = 5'b00001,
    HDR_HEIGHT = 5'b00010,
    HDR_XOFF   = 5'b00100,
    HDR_YOFF   = 5'b01000,
    HDR_MASK   = 5'b10000
  } hdr_e;

  hdr_e                          state_q, state_d;
  logic [7:0]                    width_q, width_d;
  logic [7:0]                    height_q, height_d;
  logic signed [COORD_BITS-1:0]  start_x_q, start_x_d;
  logic signed [COORD_BITS-1:0]  start_y_q, start_y_d;
  logic signed [ORIGIN_BITS-1:0] origin_x_q, origin_x_d;
  logic signed [ORIGIN_BITS-1:0] origin_y_q, origin_y_d;
  logic [7:0]                    col_q, col_d;
  logic [7:0]                    row_q, row_d;

  logic                          accept;
  logic signed [7:0]             byte_s;
  logic signed [ORIGIN_BITS-1:0] px, py;
  logic                          in_view;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;
  assign byte_s     = $signed(in_data_i.sprite_byte);

  assign px = origin_x_q + $signed({{(ORIGIN_BITS-8){1'b0}}, col_q});
  assign py = origin_y_q + $signed({{(ORIGIN_BITS-8){1'b0}}, row_q});

  // Inclusive viewport; an inverted range simply never matches.
  assign in_view = (px >= $signed({{(ORIGIN_BITS-VP_BITS){1'b0}}, cfg_i.vp_x_min})) &&
                   (px <= $signed({{(ORIGIN_BITS-VP_BITS){1'b0}}, cfg_i.vp_x_max})) &&
                   (py >= $signed({{(ORIGIN_BITS-VP_BITS){1'b0}}, cfg_i.vp_y_min})) &&
                   (py <= $signed({{(ORIGIN_BITS-VP_BITS){1'b0}}, cfg_i.vp_y_max}));

  assign pix_o.px = px[VP_BITS-1:0];
  assign pix_o.py = py[VP_BITS-1:0];

  always_comb begin
    state_d    = state_q;
    width_d    = width_q;
    height_d   = height_q;
    start_x_d  = start_x_q;
    start_y_d  = start_y_q;
    origin_x_d = origin_x_q;
    origin_y_d = origin_y_q;
    col_d      = col_q;
    row_d      = row_q;
    push_o     = 1'b0;
    if (accept) begin
      if (in_data_i.first) begin
        // restart header, any unfinished sprite is dropped
        width_d   = in_data_i.sprite_byte;
        start_x_d = in_data_i.pos_x;
        start_y_d = in_data_i.pos_y;
        col_d     = '0;
        row_d     = '0;
        state_d   = HDR_HEIGHT;
      end else begin
        case (state_q)
          HDR_IDLE: begin
            state_d = HDR_IDLE;
          end
          HDR_HEIGHT: begin
            height_d = in_data_i.sprite_byte;
            state_d  = HDR_XOFF;
          end
          HDR_XOFF: begin
            origin_x_d = ORIGIN_BITS'(start_x_q) + ORIGIN_BITS'(byte_s);
            state_d    = HDR_YOFF;
          end
          HDR_YOFF: begin
            origin_y_d = ORIGIN_BITS'(start_y_q) + ORIGIN_BITS'(byte_s);
            col_d      = '0;
            row_d      = '0;
            state_d    = (width_q == '0 || height_q == '0) ? HDR_IDLE : HDR_MASK;
          end
          HDR_MASK: begin
            push_o = (in_data_i.sprite_byte != '0) && in_view;
            if ({1'b0, col_q} + 9'd1 >= {1'b0, width_q}) begin
              col_d = '0;
              if ({1'b0, row_q} + 9'd1 >= {1'b0, height_q}) begin
                row_d   = '0;
                state_d = HDR_IDLE;
              end else begin
                row_d = row_q + 8'd1;
              end
            end else begin
              col_d = col_q + 8'd1;
            end
          end
          default: begin
            state_d = HDR_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= HDR_IDLE;
      width_q    <= '0;
      height_q   <= '0;
      start_x_q  <= '0;
      start_y_q  <= '0;
      origin_x_q <= '0;
      origin_y_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      state_q    <= state_d;
      width_q    <= width_d;
      height_q   <= height_d;
      start_x_q  <= start_x_d;
      start_y_q  <= start_y_d;
      origin_x_q <= origin_x_d;
      origin_y_q <= origin_y_d;
      col_q      <= col_d;
      row_q      <= row_d;
    end
  end

endmodule

[src/mscb_fifo.sv]
`include "mono_sprite_clip_blit_defines.svh"

module mscb_fifo
  import mscb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pix_t pix_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output pix_t pix_o
);

  localparam int unsigned PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(FIFO_DEPTH + 1);

  pix_t                entries_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] count_q;

  assign full_o  = (count_q == CNT_BITS'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign pix_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_BITS'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_BITS'(1);
      end
    end
  end

  `MSCB_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_BITS'(FIFO_DEPTH), "fifo count overrun")
  `MSCB_ASSERT(a_no_push_full, push_i |-> !full_o, "push into full fifo")
  `MSCB_ASSERT(a_no_pop_empty, pop_i |-> valid_o, "pop from empty fifo")
  `MSCB_ASSERT(a_count_up, (push_i && !pop_i) |=> count_q == $past(count_q) + CNT_BITS'(1), "fifo count did not rise")

endmodule

[src/mscb_back.sv]
module mscb_back
  import mscb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      fifo_valid_i,
  input  pix_t      pix_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  logic                        out_valid_q;
  out_word_t                   out_q, out_d;
  logic [VP_BITS+1:0]          x_off;
  logic [VP_BITS+PITCH_BITS-1:0] y_off;

  assign pop_o = fifo_valid_i && (!out_valid_q || !out_stall_i);

  assign x_off = cfg_i.wide_pixels ? {pix_i.px, 2'b00} : {1'b0, pix_i.px, 1'b0};
  assign y_off = pix_i.py * cfg_i.line_pitch;

  always_comb begin
    out_d.write_address = ADDR_BITS'(cfg_i.frame_base) + ADDR_BITS'(x_off)
                        + ADDR_BITS'(y_off);
    out_d.write_data    = cfg_i.wide_pixels ? cfg_i.draw_colour
        : {{(DATA_BITS-NARROW_PIXEL_BITS){1'b0}}, cfg_i.draw_colour[NARROW_PIXEL_BITS-1:0]};
    out_d.write_wide    = cfg_i.wide_pixels;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[src/mono_sprite_clip_blit.sv]
// Clipped monochrome sprite blitter.
// Input channel (in_valid_i / in_stall_o / in_data_i): one sprite byte per word.
//   A word with first set starts a sprite (its byte is the width, pos_x/pos_y
//   are sampled); then height, signed x offset, signed y offset and the mask
//   bytes in row order follow.
// Output channel (out_valid_o / out_stall_i / out_data_o): one framebuffer
//   write per drawn pixel - nonzero mask byte inside the inclusive viewport.
// Config channel (cfg_valid_i / cfg_ready_o): ready is always high; index and
//   data write one register. Unknown indexes are dropped. Write while idle.
// Throughput: one input word and one result word per cycle when not stalled.
// Path: a drawing mask byte, once accepted, passes the header parser and clip
//   test into a 4-word queue; the write generator (one 12x16 multiply plus
//   add) pops it from there into the output reg.
// Stall: a valid output word holds while out_stall_i is high, the queue
//   fills behind it and in_stall_o rises once all four slots are taken.
// Reset: registers return to their defaults (640x480 viewport, pitch 1280,
//   16-bit pixels), the parser goes idle and queue and output are emptied.
module mono_sprite_clip_blit
  import mscb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_word_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_word_t               out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [31:0]             cfg_data_i
);

  cfg_t cfg_q;
  logic fifo_full, fifo_valid, push, pop;
  pix_t push_pix, pop_pix;

  assign cfg_ready_o = 1'b1;

  // Register file; each write keeps only the field's own bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_VP_X_MIN:   cfg_q.vp_x_min    <= cfg_data_i[VP_BITS-1:0];
        CFG_VP_X_MAX:   cfg_q.vp_x_max    <= cfg_data_i[VP_BITS-1:0];
        CFG_VP_Y_MIN:   cfg_q.vp_y_min    <= cfg_data_i[VP_BITS-1:0];
        CFG_VP_Y_MAX:   cfg_q.vp_y_max    <= cfg_data_i[VP_BITS-1:0];
        CFG_LINE_PITCH: cfg_q.line_pitch  <= cfg_data_i[PITCH_BITS-1:0];
        CFG_FRAME_BASE: cfg_q.frame_base  <= cfg_data_i;
        CFG_COLOUR:     cfg_q.draw_colour <= cfg_data_i[DATA_BITS-1:0];
        CFG_WIDE:       cfg_q.wide_pixels <= cfg_data_i[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // front: header parse, counters, clip test
  mscb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .pix_o       (push_pix)
  );

  // queue of visible pixels
  mscb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pix_i   (push_pix),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .pix_o   (pop_pix)
  );

  // back: address and data generation, output register
  mscb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fifo_valid_i (fifo_valid),
    .pix_i        (pop_pix),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

[bench/mono_sprite_clip_blit_test.sv]
`timescale 1ns / 100ps

// Sprite words go in on the input channel. A model of the header parser and
// the clip test runs on every accepted word and queues the framebuffer writes
// it expects. Every write the blitter hands out is checked, field by field,
// against the oldest write in that queue.
module mono_sprite_clip_blit_test;
  import mscb_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned SETTLE_CYCLES   = 4;   // queue plus output register
  localparam int unsigned END_CYCLES      = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned PHASES          = 9;
  localparam int unsigned PHASE_WORDS     = 200;
  localparam int unsigned VP_TOP          = 4095;
  localparam int unsigned FIRST_SPARE_IDX = 8;   // indexes above the last register
  localparam int unsigned LAST_IDX        = 2 ** CFG_IDX_BITS - 1;

  // Where the header parser stands.
  typedef enum int {
    PARSE_IDLE,
    PARSE_HEIGHT,
    PARSE_X_OFF,
    PARSE_Y_OFF,
    PARSE_MASK
  } parse_e;

  // Our copy of the register file.
  typedef struct packed {
    logic [11:0] x_min;
    logic [11:0] x_max;
    logic [11:0] y_min;
    logic [11:0] y_max;
    logic [15:0] pitch;
    logic [31:0] base;
    logic [31:0] colour;
    logic        wide;
  } draw_setup_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  mono_sprite_clip_blit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Register state after reset: 640x480 viewport, pitch 1280, 16-bit pixels.
  draw_setup_t view = '{x_min: 12'd0, x_max: 12'd639, y_min: 12'd0, y_max: 12'd479,
                        pitch: 16'd1280, base: 32'd0, colour: 32'd0, wide: 1'b0};

  // Parser state.
  parse_e parse = PARSE_IDLE;
  int     spr_w, spr_h;
  int     anchor_x, anchor_y;   // position sampled with the width word
  int     org_x, org_y;         // anchor plus the signed offsets
  int     col, row;             // where the next mask byte lands

  out_word_t pending_writes[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned sprite_words = 0;

  // Sender pacing.
  bit          gaps_on = 1'b1;
  int unsigned burst_left = 0;
  bit          hold_off_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void store_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [31:0] data);
    case (idx)
      CFG_VP_X_MIN:   view.x_min = data[11:0];
      CFG_VP_X_MAX:   view.x_max = data[11:0];
      CFG_VP_Y_MIN:   view.y_min = data[11:0];
      CFG_VP_Y_MAX:   view.y_max = data[11:0];
      CFG_LINE_PITCH: view.pitch = data[15:0];
      CFG_FRAME_BASE: view.base = data;
      CFG_COLOUR:     view.colour = data;
      CFG_WIDE:       view.wide = data[0];
      default: ;      // unknown index, dropped by the block too
    endcase
  endfunction

  // Runs the parser on one accepted word; queues a write for a drawn pixel.
  function automatic void predict_blit(input in_word_t w);
    int          px, py;
    logic [31:0] ux, uy;
    out_word_t   wr;
    // A width word restarts the header whatever state we are in.
    if (w.first) begin
      spr_w = int'(w.sprite_byte);
      anchor_x = int'($signed(w.pos_x));
      anchor_y = int'($signed(w.pos_y));
      col = 0;
      row = 0;
      parse = PARSE_HEIGHT;
      return;
    end
    case (parse)
      PARSE_HEIGHT: begin
        spr_h = int'(w.sprite_byte);
        parse = PARSE_X_OFF;
      end
      PARSE_X_OFF: begin
        org_x = anchor_x + int'($signed(w.sprite_byte));
        parse = PARSE_Y_OFF;
      end
      PARSE_Y_OFF: begin
        org_y = anchor_y + int'($signed(w.sprite_byte));
        col = 0;
        row = 0;
        // zero-sized sprite carries no mask bytes
        parse = (spr_w == 0 || spr_h == 0) ? PARSE_IDLE : PARSE_MASK;
      end
      PARSE_MASK: begin
        px = org_x + col;
        py = org_y + row;
        if (w.sprite_byte != 8'd0 &&
            px >= int'(view.x_min) && px <= int'(view.x_max) &&
            py >= int'(view.y_min) && py <= int'(view.y_max)) begin
          ux = px;
          uy = py;
          // 32-bit wrap falls out of the operand widths
          wr.write_address = view.base + ux * (view.wide ? 32'd4 : 32'd2) +
                             uy * {16'd0, view.pitch};
          wr.write_data = view.wide ? view.colour : {16'd0, view.colour[15:0]};
          wr.write_wide = view.wide;
          pending_writes.push_back(wr);
        end
        if (col + 1 >= spr_w) begin
          col = 0;
          row++;
          if (row >= spr_h) begin
            row = 0;
            parse = PARSE_IDLE;
          end
        end else begin
          col++;
        end
      end
      default: parse = PARSE_IDLE;   // stray byte, ignored
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_write(input out_word_t got);
    out_word_t want;
    if (pending_writes.size() == 0) begin
      $display("%0t: unexpected write, expected none, got addr %h data %h wide %b",
               $time, got.write_address, got.write_data, got.write_wide);
      mismatches++;
      return;
    end
    want = pending_writes.pop_front();
    if (got.write_address !== want.write_address) begin
      $display("%0t: write_address expected %h got %h", $time,
               want.write_address, got.write_address);
      mismatches++;
    end
    if (got.write_data !== want.write_data) begin
      $display("%0t: write_data expected %h got %h", $time,
               want.write_data, got.write_data);
      mismatches++;
    end
    if (got.write_wide !== want.write_wide) begin
      $display("%0t: write_wide expected %b got %b", $time,
               want.write_wide, got.write_wide);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_write(out_data_o);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d writes outstanding", $time,
               pending_writes.size());
      $display("FAIL mono_sprite_clip_blit");
      $finish;
    end
  end

  // Receiver: segments of random length, each with its own stall density
  // (zero included, so there are clean stretches). A hold-off request
  // parks the stall high for a long count so the queue backs up.
  initial begin : rx_pattern
    int unsigned seg_left;
    int unsigned density;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 48);
          case ($urandom_range(0, 3))
            0: density = 0;
            1: density = 20;
            2: density = 50;
            default: density = 85;
          endcase
        end
        seg_left--;
        out_stall_i <= ($urandom_range(0, 99) < density);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_word_t make_word(input logic first, input logic [7:0] b,
                                         input logic [15:0] x, input logic [15:0] y);
    in_word_t w;
    w.first = first;
    w.sprite_byte = b;
    w.pos_x = x;
    w.pos_y = y;
    return w;
  endfunction

  // Offers one word, bursts and gaps decided here; predicts on acceptance.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 2);
      if (gaps_on && gap > 0) begin
        in_valid_i <= 1'b0;
        in_data_i <= make_word(1'b0, 8'($urandom), 16'($urandom), 16'($urandom));
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    predict_blit(w);
  endtask

  // Position fields are junk on non-first words; the block must ignore them.
  task automatic send_byte(input logic [7:0] b);
    send_word(make_word(1'b0, b, 16'($urandom), 16'($urandom)));
  endtask

  function automatic logic [7:0] ink_byte(input int unsigned pct);
    return ($urandom_range(0, 99) < pct) ? 8'($urandom_range(1, 255)) : 8'd0;
  endfunction

  // Header then mask bytes; stops after count words (truncated sprite).
  task automatic send_sprite(input int unsigned wd, input int unsigned ht,
                             input logic [15:0] px, input logic [15:0] py,
                             input logic [7:0] xoff, input logic [7:0] yoff,
                             input int unsigned ink_pct, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      case (i)
        0: send_word(make_word(1'b1, 8'(wd), px, py));
        1: send_byte(8'(ht));
        2: send_byte(xoff);
        3: send_byte(yoff);
        default: send_byte(ink_byte(ink_pct));
      endcase
    end
    sprite_words += count;
  endtask

  // Drops valid and waits out every queued write plus the pipeline depth.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    store_reg(idx, data);
  endtask

  // Writes every register; bits above a field's width are random and must
  // be dropped. One write to a spare index sits in the middle.
  task automatic apply_settings(input draw_setup_t s);
    write_reg(CFG_VP_X_MIN, {20'($urandom), s.x_min});
    write_reg(CFG_VP_X_MAX, {20'($urandom), s.x_max});
    write_reg(CFG_VP_Y_MIN, {20'($urandom), s.y_min});
    write_reg(CFG_VP_Y_MAX, {20'($urandom), s.y_max});
    write_reg(CFG_IDX_BITS'($urandom_range(FIRST_SPARE_IDX, LAST_IDX)), $urandom);
    write_reg(CFG_LINE_PITCH, {16'($urandom), s.pitch});
    write_reg(CFG_FRAME_BASE, s.base);
    write_reg(CFG_COLOUR, s.colour);
    write_reg(CFG_WIDE, {31'($urandom), s.wide});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic draw_setup_t pick_setup(input int k);
    draw_setup_t s;
    int          hi;
    s.pitch = 16'($urandom);
    s.base = $urandom;
    s.colour = $urandom;
    s.wide = 1'($urandom);
    case (k)
      0: begin
        // whole coordinate range, widest pitch, base just below the wrap
        s.x_min = 12'd0;
        s.x_max = 12'(VP_TOP);
        s.y_min = 12'd0;
        s.y_max = 12'(VP_TOP);
        s.pitch = 16'hFFFF;
        s.base = 32'hFFFF_FF00;
        s.colour = 32'hFFFF_FFFF;
        s.wide = 1'b1;
      end
      1: begin
        // inverted x window: nothing may be drawn
        s.x_min = 12'd300;
        s.x_max = 12'd100;
        s.y_min = 12'd0;
        s.y_max = 12'd479;
        s.wide = 1'b0;
        s.colour = 32'hFFFF_FFFF;
      end
      2: begin
        // single pixel at the far corner, zero pitch
        s.x_min = 12'(VP_TOP);
        s.x_max = 12'(VP_TOP);
        s.y_min = 12'(VP_TOP);
        s.y_max = 12'(VP_TOP);
        s.pitch = 16'd0;
      end
      3: begin
        // one column at x = 0, full height
        s.x_min = 12'd0;
        s.x_max = 12'd0;
        s.y_min = 12'd0;
        s.y_max = 12'(VP_TOP);
        s.wide = 1'b0;
      end
      default: begin
        // small window somewhere, so sprites straddle its edges often
        s.x_min = 12'($urandom_range(0, VP_TOP));
        hi = int'(s.x_min) + int'($urandom_range(0, 80));
        s.x_max = (hi > VP_TOP) ? 12'(VP_TOP) : 12'(hi);
        s.y_min = 12'($urandom_range(0, VP_TOP));
        hi = int'(s.y_min) + int'($urandom_range(0, 60));
        s.y_max = (hi > VP_TOP) ? 12'(VP_TOP) : 12'(hi);
      end
    endcase
    return s;
  endfunction

  // A coordinate a little either side of the window (its minimum if inverted).
  function automatic int near_window(input logic [11:0] lo, input logic [11:0] hi);
    int a, b;
    a = int'(lo);
    b = int'(hi);
    if (b < a) b = a;
    return a - 12 + int'($urandom_range(0, b - a + 24));
  endfunction

  // Mostly well-formed sprites aimed at the window; some empty, some long
  // thin ones, some cut short, some stray bytes after them.
  task automatic random_sprite();
    int unsigned wd, ht, total, cut, roll;
    logic [7:0]  xoff, yoff;
    logic [15:0] px, py;
    roll = $urandom_range(0, 99);
    wd = $urandom_range(1, 10);
    ht = $urandom_range(1, 6);
    if (roll < 3) wd = 0;
    else if (roll < 6) ht = 0;
    else if (roll < 9) begin
      wd = $urandom_range(100, 255);
      ht = $urandom_range(1, 2);
    end
    xoff = 8'($urandom);
    yoff = 8'($urandom);
    px = 16'(near_window(view.x_min, view.x_max) - int'($signed(xoff)));
    py = 16'(near_window(view.y_min, view.y_max) - int'($signed(yoff)));
    // full-range positions now and then, sign bit included
    if ($urandom_range(0, 9) == 0) px = 16'($urandom);
    if ($urandom_range(0, 9) == 0) py = 16'($urandom);
    total = 4 + wd * ht;
    cut = ($urandom_range(0, 99) < 5) ? $urandom_range(1, total - 1) : total;
    send_sprite(wd, ht, px, py, xoff, yoff, $urandom_range(0, 100), cut);
    if ($urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register defaults: 640x480, pitch 1280, narrow, colour zero.
  task automatic test_reset_defaults();
    // 2x2 at the top-left corner, one blank byte among them
    send_sprite(2, 2, 16'd0, 16'd0, 8'd0, 8'd0, 0, 4);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h80);
    // 2x1 on the bottom-right corner, second pixel just off the right edge
    send_sprite(2, 1, 16'd639, 16'd479, 8'd0, 8'd0, 0, 4);
    send_byte(8'h7F);
    send_byte(8'hFF);
    wait_drained();
  endtask

  // Extreme header values, restart mid-stream, empty sprite, stray bytes.
  task automatic test_restart_and_empty();
    // largest sprite at the most negative x / most positive y, offsets at
    // their extremes; far off screen so no write
    send_sprite(255, 255, 16'h8000, 16'h7FFF, 8'h80, 8'h7F, 100, 5);
    // new width word mid-mask drops it; the 1x1 lands at (4,6)
    send_sprite(1, 1, 16'd5, 16'd5, 8'hFF, 8'h01, 100, 5);
    // width zero: back to idle after the y offset, next byte is stray
    send_sprite(0, 5, 16'd0, 16'd0, 8'd0, 8'd0, 0, 4);
    send_byte(8'hFF);
    wait_drained();
  endtask

  // Receiver holds off for a long while; sender keeps offering, so the
  // four-word queue fills and the input stall must rise.
  task automatic test_output_backpressure();
    hold_off_req = 1'b1;
    gaps_on = 1'b0;
    send_sprite(8, 4, 16'd100, 16'd50, 8'd0, 8'd0, 100, 36);
    gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_sprites();
    int unsigned start;
    for (int k = 0; k < PHASES; k++) begin
      wait_drained();
      apply_settings(pick_setup(k));
      start = sprite_words;
      while (sprite_words - start < PHASE_WORDS) random_sprite();
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_restart_and_empty();
    test_output_backpressure();
    test_random_sprites();
    // catch any write the model did not ask for
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("PASS mono_sprite_clip_blit");
    end else begin
      $display("FAIL mono_sprite_clip_blit");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/mscb_pkg.sv
src/mscb_front.sv
src/mscb_fifo.sv
src/mscb_back.sv
src/mono_sprite_clip_blit.sv
bench/mono_sprite_clip_blit_test.sv
